/* src/sitbd_pkg.sv */
package sitbd_pkg;

  // field and register widths
  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int CNT_W     = 5;
  localparam int TBL_W     = 64;
  localparam int CFG_IDX_W = 8;

  // digit table
  localparam int MAX_DIGITS  = 16;
  localparam int TBL_ENTRIES = 16;
  localparam int DIG_W       = 4;

  // digit stack: one entry per possible magnitude digit
  localparam int STK_DEPTH = 32;
  localparam int STK_IDX_W = 5;
  localparam int ND_W      = 6;

  // restoring divider: quotient bits resolved per cycle
  localparam int BITS_PER_CYCLE  = 8;
  localparam int STEPS_PER_DIGIT = VALUE_W / BITS_PER_CYCLE;
  localparam int STEP_W          = 2;

  // characters
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic table_ok;
    logic digit_end;
    logic quo_zero;
    logic nd_full;
    logic neg;
    logic nd_one;
    logic out_free;
  } sts_t;

endpackage

/* src/sitbd_in_if.sv */
interface sitbd_in_if import sitbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* src/sitbd_out_if.sv */
interface sitbd_out_if import sitbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* src/sitbd_cfg_if.sv */
interface sitbd_cfg_if import sitbd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TBL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/signed_integer_to_base_digits_top.sv */
// Signed integer to digits in a configured radix.
// in_ch carries one 32-bit two's complement value per word; out_ch returns
// one character per word, '-' first for a negative value, then the digits of
// the exact magnitude, most significant first, with last set on the final
// character. cfg_ch writes digit_count (index 0), digits_low (1) and
// digits_high (2); the radix is digit_count. A table with fewer than two
// entries, more than 16, a repeated character or a '+' or '-' makes a value
// produce no characters. Write configuration only while the block is idle.
// One value is converted at a time. After acceptance, the CHECK state
// checks the table, then a shared restoring divider resolves 8 quotient bits
// a cycle, one digit at a time; characters then leave at one per cycle while
// out_ch.ready stays high. The next value is accepted only once the
// controller is back in idle; a rejected table returns it from the check
// straight to idle.
// When out_ch.ready is low the output register holds its word and the
// conversion waits. Synchronous reset clears the table registers to zero,
// the controller to idle and the output valid.
module signed_integer_to_base_digits_top import sitbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sitbd_in_if.sink    in_ch,
  sitbd_out_if.source out_ch,
  sitbd_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  // controller
  sitbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sitbd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_ch.value),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

/* src/sitbd_ctrl.sv */
module sitbd_ctrl import sitbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.table_ok ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.digit_end && (sts.quo_zero || sts.nd_full)) begin
          state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.nd_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // division only follows a passed check or more division
  a_divide_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |->
      ($past(state_r) == ST_CHECK) || ($past(state_r) == ST_DIVIDE))
    else $error("divide entered from wrong state");

  // a sign is only emitted for a negative value
  a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sign |-> sts.neg)
    else $error("sign emitted for non-negative value");
`endif

endmodule

/* src/sitbd_dp.sv */
module sitbd_dp import sitbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input word
  input  logic [VALUE_W-1:0]   in_value,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TBL_W-1:0]     cfg_data,
  // result words
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAR_W-1:0]    out_character,
  output logic                 out_last,
  // control
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  logic [CNT_W-1:0]     digit_count_r;
  logic [TBL_W-1:0]     digits_low_r;
  logic [TBL_W-1:0]     digits_high_r;
  logic [CHAR_W-1:0]    tbl_chars [TBL_ENTRIES];
  logic                 table_ok;

  logic [VALUE_W-1:0]   mag_r;
  logic [VALUE_W-1:0]   mag_nxt;
  logic [DIG_W-1:0]     rem_r;
  logic [DIG_W-1:0]     rem_nxt;
  logic                 neg_r;
  logic [STEP_W-1:0]    step_r;
  logic [ND_W-1:0]      nd_r;
  logic [DIG_W-1:0]     stk_r [STK_DEPTH];
  logic [STK_IDX_W-1:0] top_idx;

  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;
  logic                 digit_end;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= '0;
      digits_low_r  <= '0;
      digits_high_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIGIT_COUNT: digit_count_r <= cfg_data[CNT_W-1:0];
        REG_DIGITS_LOW:  digits_low_r  <= cfg_data;
        REG_DIGITS_HIGH: digits_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // digit table as characters
  for (genvar k = 0; k < TBL_ENTRIES / 2; k++) begin : g_tbl
    assign tbl_chars[k]                   = digits_low_r[k*CHAR_W +: CHAR_W];
    assign tbl_chars[k + TBL_ENTRIES / 2] = digits_high_r[k*CHAR_W +: CHAR_W];
  end

  // table check: radix range, no sign characters, no repeats
  always_comb begin
    table_ok = (digit_count_r >= CNT_W'(2)) && (digit_count_r <= CNT_W'(MAX_DIGITS));
    for (int a = 0; a < TBL_ENTRIES; a++) begin
      if (CNT_W'(a) < digit_count_r) begin
        if (tbl_chars[a] == CHAR_PLUS || tbl_chars[a] == CHAR_MINUS) begin
          table_ok = 1'b0;
        end
        for (int b = a + 1; b < TBL_ENTRIES; b++) begin
          if (CNT_W'(b) < digit_count_r && tbl_chars[b] == tbl_chars[a]) begin
            table_ok = 1'b0;
          end
        end
      end
    end
  end

  // restoring divider slice, several quotient bits per cycle
  always_comb begin
    logic [DIG_W:0] trial;
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial = {rem_nxt, mag_nxt[VALUE_W-1]};
      if (trial >= digit_count_r && digit_count_r != '0) begin
        rem_nxt = DIG_W'(trial - digit_count_r);
        mag_nxt = {mag_nxt[VALUE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIG_W-1:0];
        mag_nxt = {mag_nxt[VALUE_W-2:0], 1'b0};
      end
    end
  end

  assign digit_end = (step_r == STEP_W'(STEPS_PER_DIGIT - 1));
  assign top_idx   = STK_IDX_W'(nd_r - ND_W'(1));

  // control state of the conversion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      nd_r   <= '0;
    end else if (cmd.load) begin
      step_r <= '0;
      nd_r   <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + STEP_W'(1);
      if (digit_end) begin
        nd_r <= nd_r + ND_W'(1);
      end
    end else if (cmd.emit_digit) begin
      nd_r <= nd_r - ND_W'(1);
    end
  end

  // magnitude, remainder and digit stack
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_value[VALUE_W-1];
      mag_r <= in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      mag_r <= mag_nxt;
      rem_r <= digit_end ? '0 : rem_nxt;
      if (digit_end) begin
        stk_r[nd_r[STK_IDX_W-1:0]] <= rem_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= tbl_chars[stk_r[top_idx]];
      out_last_r <= (nd_r == ND_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // status
  assign sts.table_ok  = table_ok;
  assign sts.digit_end = digit_end;
  assign sts.quo_zero  = (mag_nxt == '0);
  assign sts.nd_full   = (nd_r == ND_W'(STK_DEPTH - 1));
  assign sts.neg       = neg_r;
  assign sts.nd_one    = (nd_r == ND_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

`ifndef NO_ASSERTIONS
  // a digit is never pushed onto a full stack
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && digit_end) |-> (nd_r < ND_W'(STK_DEPTH)))
    else $error("digit stack overflow");

  // a digit is never popped from an empty stack
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> (nd_r != '0))
    else $error("digit stack underflow");
`endif

endmodule

/* tb/sv/signed_integer_to_base_digits_top_tb.sv */
module signed_integer_to_base_digits_top_tb import sitbd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_VALUES   = 120;
  // long enough for any conversion still in flight to finish
  localparam int DRAIN_CYCLES    = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  // worst case: every value with the longest output stalls is well under this
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTS     = 100;
  localparam int MIN_RADIX       = 2;
  localparam int REG_LIMIT       = 31;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;
  localparam logic [VALUE_W-1:0]   VAL_MIN      = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0]   VAL_MAX      = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef logic [TBL_ENTRIES-1:0][CHAR_W-1:0] digit_table_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } char_word_t;

  // mirrors the digit table and queues the characters each value must spell
  class char_stream_checker;
    logic [CNT_W-1:0] radix;
    digit_table_t     digit_tbl;
    char_word_t       chars_due[$];
    int               errors;
    int               reports;
    int               words_checked;

    function new();
      radix         = '0;
      digit_tbl     = '0;
      errors        = 0;
      reports       = 0;
      words_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TBL_W-1:0] data);
      case (idx)
        REG_DIGIT_COUNT: radix = data[CNT_W-1:0];
        REG_DIGITS_LOW:  digit_tbl[7:0] = data;
        REG_DIGITS_HIGH: digit_tbl[15:8] = data;
        default: ;
      endcase
    endfunction

    function bit table_usable();
      logic [CHAR_W-1:0] c;
      if (radix < MIN_RADIX || radix > MAX_DIGITS) return 1'b0;
      for (int a = 0; a < radix; a++) begin
        c = digit_tbl[a];
        if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
        for (int b = a + 1; b < radix; b++)
          if (digit_tbl[b] == c) return 1'b0;
      end
      return 1'b1;
    endfunction

    // queue the characters of one accepted value, return how many
    function int spell_value(logic [VALUE_W-1:0] value);
      logic [VALUE_W:0] mag;
      logic [DIG_W-1:0] digs[$];
      char_word_t       w;
      int               n;
      if (!table_usable()) return 0;
      mag = value[VALUE_W-1] ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
      do begin
        digs.push_front(DIG_W'(mag % radix));
        mag = mag / radix;
      end while (mag != 0);
      n = 0;
      if (value[VALUE_W-1]) begin
        w.character = CHAR_MINUS;
        w.last      = 1'b0;
        chars_due.push_back(w);
        n++;
      end
      foreach (digs[k]) begin
        w.character = digit_tbl[digs[k]];
        w.last      = (k == digs.size() - 1);
        chars_due.push_back(w);
        n++;
      end
      return n;
    endfunction

    function void complain(string what, int want, int got);
      errors++;
      if (reports < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      else if (reports == MAX_REPORTS)
        $display("%0t: further mismatches counted but not shown", $time);
      reports++;
    endfunction

    // compare one output word against the oldest expected character
    function void take_char(logic [CHAR_W-1:0] character, logic last);
      char_word_t want;
      words_checked++;
      if (chars_due.size() == 0) begin
        complain("unexpected word (none pending)", -1, {character, last});
        return;
      end
      want = chars_due.pop_front();
      if (character !== want.character) complain("character", want.character, character);
      if (last !== want.last) complain("last", want.last, last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  bit   no_gaps = 1'b0;
  bit   hold_off_due = 1'b0;
  int   values_sent = 0;
  int   values_spelled = 0;
  int   settings = 0;

  char_stream_checker board = new();

  sitbd_in_if  in_ch();
  sitbd_out_if out_ch();
  sitbd_cfg_if cfg_ch();

  signed_integer_to_base_digits_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none in quiet phases
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int                 r;
    logic [VALUE_W-1:0] v;
    r = $urandom_range(0, 99);
    v = $urandom();
    if (r < 45) return v;
    if (r < 65) return $signed(v) >>> $urandom_range(1, VALUE_W - 1);
    if (r < 85) return VALUE_W'($urandom_range(0, 600)) - VALUE_W'(300);
    case ($urandom_range(0, 3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // first n entries distinct and free of sign characters, rest arbitrary
  function automatic digit_table_t random_table(int n);
    digit_table_t      t;
    bit [255:0]        taken;
    logic [CHAR_W-1:0] c;
    taken = '0;
    taken[CHAR_PLUS] = 1'b1;
    taken[CHAR_MINUS] = 1'b1;
    for (int k = 0; k < TBL_ENTRIES; k++) begin
      if (k < n) begin
        do c = CHAR_W'($urandom_range(0, 255)); while (taken[c]);
        taken[c] = 1'b1;
      end else begin
        c = CHAR_W'($urandom_range(0, 255));
      end
      t[k] = c;
    end
    return t;
  endfunction

  function automatic digit_table_t table_from_string(string s);
    digit_table_t t;
    for (int k = 0; k < TBL_ENTRIES; k++)
      t[k] = (k < s.len()) ? s[k] : CHAR_W'($urandom_range(0, 255));
    return t;
  endfunction

  // output side: random stalls plus one long hold-off on request
  initial begin : char_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // check every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.take_char(out_ch.character, out_ch.last);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TBL_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // count goes in with random upper bits, which the block must drop
  task automatic load_table(input int count, input digit_table_t tbl);
    logic [TBL_W-1:0] data;
    data = {$urandom(), $urandom()};
    data[CNT_W-1:0] = CNT_W'(count);
    write_reg(REG_DIGIT_COUNT, data);
    write_reg(REG_DIGITS_LOW, tbl[7:0]);
    write_reg(REG_DIGITS_HIGH, tbl[15:8]);
    settings++;
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    values_sent++;
    if (board.spell_value(v) != 0) values_spelled++;
  endtask

  // wait for every expected character, then let a silent conversion finish
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    digit_table_t tbl;
    int           cnt;
    int           kind;
    int           n_items;
    int           a;
    int           b;
    int           phase;
    int           goal;
    bit           want_ok;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset table has no radix, so these spell nothing
    send_value('0);
    send_value('1);
    settle();

    // decimal, then an unmapped write that must leave the table alone
    load_table(10, table_from_string("0123456789"));
    write_reg(REG_UNMAPPED, {8{CHAR_MINUS}});
    send_value('0);
    send_value(VALUE_W'(7));
    send_value(-VALUE_W'(7));
    send_value(VAL_MAX);
    send_value(VAL_MIN);
    send_value(VALUE_W'(1000000000));
    settle();

    // binary: most negative value gives the longest word stream
    load_table(2, table_from_string("01"));
    send_value(VAL_MIN);
    send_value('1);
    send_value(VAL_MAX);
    send_value('0);
    settle();

    // full sixteen-entry table with a zero byte and an all-ones byte
    tbl = table_from_string("x123456789abcdey");
    tbl[0] = '0;
    tbl[15] = '1;
    load_table(MAX_DIGITS, tbl);
    send_value(32'hDEADBEEF);
    send_value(VALUE_W'(255));
    send_value(VAL_MAX);
    send_value(VALUE_W'(16));
    settle();

    // broken tables: each value is swallowed
    load_table(1, tbl);
    send_value(VALUE_W'(5));
    settle();
    load_table(MAX_DIGITS + 1, tbl);
    send_value(VALUE_W'(5));
    settle();
    load_table(REG_LIMIT, tbl);
    send_value(VAL_MIN);
    settle();
    load_table(0, tbl);
    send_value(VALUE_W'(3));
    settle();
    tbl = table_from_string("0123456789abcdef");
    tbl[15] = CHAR_MINUS;
    load_table(MAX_DIGITS, tbl);
    send_value('1);
    settle();
    tbl = table_from_string("+123456789abcdef");
    load_table(MAX_DIGITS, tbl);
    send_value(VALUE_W'(42));
    settle();
    tbl = table_from_string("0123456789abcde0");
    load_table(MAX_DIGITS, tbl);
    send_value(VALUE_W'(42));
    settle();

    // sign character just past the used entries is fine
    tbl = table_from_string("abc-");
    load_table(3, tbl);
    send_value(-VALUE_W'(5));
    send_value(VALUE_W'(9));
    settle();

    // random tables and values; one phase holds the output off for a long time
    goal = values_spelled + RANDOM_VALUES;
    phase = 0;
    while (values_spelled < goal) begin
      settle();
      want_ok = ($urandom_range(0, 9) < 8) || (phase == 1);
      case ($urandom_range(0, 9))
        0, 1:    cnt = MIN_RADIX;
        2, 3:    cnt = MAX_DIGITS;
        default: cnt = $urandom_range(MIN_RADIX + 1, MAX_DIGITS - 1);
      endcase
      tbl = random_table(cnt);
      if (!want_ok) begin
        kind = $urandom_range(0, 4);
        case (kind)
          0: cnt = $urandom_range(0, MIN_RADIX - 1);
          1: cnt = $urandom_range(MAX_DIGITS + 1, REG_LIMIT);
          2: begin
            b = $urandom_range(1, cnt - 1);
            a = $urandom_range(0, b - 1);
            tbl[b] = tbl[a];
          end
          3: tbl[$urandom_range(0, cnt - 1)] = CHAR_PLUS;
          default: tbl[$urandom_range(0, cnt - 1)] = CHAR_MINUS;
        endcase
      end
      load_table(cnt, tbl);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_DIGITS_HIGH + 1, 255)), {$urandom(), $urandom()});
      no_gaps = ($urandom_range(0, 4) == 0);
      n_items = $urandom_range(6, 18);
      if (phase == 1) begin
        n_items = 20;
        hold_off_due = 1'b1;
      end
      repeat (n_items) send_value(pick_value());
      phase++;
    end
    settle();

    $display("values sent %0d, of which %0d spelled out, %0d characters checked",
             values_sent, values_spelled, board.words_checked);
    $display("digit tables loaded %0d, radix 2 through 16 plus rejected tables",
             settings);
    if (board.chars_due.size() != 0)
      $display("%0t: %0d expected characters never came", $time, board.chars_due.size());
    if (board.errors == 0 && board.chars_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
